/* hdl/i2cms_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
// Command codes, the queued command record and reset values.
// No dependencies.
package i2cms_pkg;

	localparam logic [2:0] CMD_START    = 3'd0;
	localparam logic [2:0] CMD_STOP     = 3'd1;
	localparam logic [2:0] CMD_WRITE    = 3'd2;
	localparam logic [2:0] CMD_READ     = 3'd3;
	localparam logic [2:0] CMD_READ_ACK = 3'd4;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd36;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       send_nack;
		logic [8:0] line_samples;
	} i2cms_cmd_t;

endpackage

/* hdl/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer: with the queue empty and the phase timer run out, the first
// phase of an accepted command passes the intake, queue and job registers to the output.
// A held phase loads the phase timer with phase_ticks, an unheld phase clears it. After the
// unheld last phase of a read, the next command skips the timer. Output stalls hold phases.
// Phases: start 4, stop 3, write 27, read 21, read acknowledge 3. Commands queue meanwhile.
// Reset: both lines released, phase_ticks 36, queue and output empty.
module i2c_master_bit_sequencer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] tx_byte,
	input  logic       send_nack,
	input  logic [8:0] line_samples,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       held,
	output logic [7:0] rx_byte,
	output logic       ack_seen,
	output logic       last
);
	import i2cms_pkg::*;

	logic       push;
	i2cms_cmd_t push_cmd;
	logic       q_full;
	logic       pop;
	logic       q_valid;
	i2cms_cmd_t pop_cmd;

	i2cms_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.tx_byte      (tx_byte),
		.send_nack    (send_nack),
		.line_samples (line_samples),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_full       (q_full)
	);

	i2cms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.pop_cmd  (pop_cmd)
	);

	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl_level (scl_level),
		.sda_level (sda_level),
		.held      (held),
		.rx_byte   (rx_byte),
		.ack_seen  (ack_seen),
		.last      (last)
	);

endmodule

/* hdl/i2cms_front.sv */
// Command intake stage: accepts transactions, drops unknown commands
// and hands valid ones to the command queue. Depends on i2cms_pkg.
module i2cms_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [7:0]         tx_byte,
	input  logic               send_nack,
	input  logic [8:0]         line_samples,
	output logic               push,
	output i2cms_pkg::i2cms_cmd_t push_cmd,
	input  logic               q_full
);
	import i2cms_pkg::*;

	logic       valid_s1;
	i2cms_cmd_t cmd_s1;
	logic       known;

	assign known    = command inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_READ_ACK};
	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1.command      <= command;
			cmd_s1.tx_byte      <= tx_byte;
			cmd_s1.send_nack    <= send_nack;
			cmd_s1.line_samples <= line_samples;
		end
	end

endmodule

/* hdl/i2cms_queue.sv */
// Short command queue between intake and bus sequencer.
// Register based, one read port. Depends on i2cms_pkg.
module i2cms_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2cms_pkg::i2cms_cmd_t push_cmd,
	output logic                  full,
	input  logic                  pop,
	output logic                  q_valid,
	output i2cms_pkg::i2cms_cmd_t pop_cmd
);
	import i2cms_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	i2cms_cmd_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign q_valid = count_q != '0;
	assign pop_cmd = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* hdl/i2cms_back.sv */
// Bus phase sequencer: walks the phase run of one command, tracks the
// line levels, times held phases and drives the output register. Depends on i2cms_pkg.
module i2cms_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  q_valid,
	input  i2cms_pkg::i2cms_cmd_t pop_cmd,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  scl_level,
	output logic                  sda_level,
	output logic                  held,
	output logic [7:0]            rx_byte,
	output logic                  ack_seen,
	output logic                  last
);
	import i2cms_pkg::*;

	logic [7:0] phase_ticks_q;
	logic       active_q;
	i2cms_cmd_t job_q;
	logic [4:0] step_q;
	logic [1:0] sub_q;
	logic [3:0] grp_q;
	logic       scl_q;
	logic       sda_q;
	logic [7:0] wait_q;

	logic       emit;
	logic       nxt_scl;
	logic       nxt_sda;
	logic       nxt_held;
	logic       nxt_last;
	logic [7:0] nxt_rx;
	logic       nxt_ack;

	assign pop  = !active_q && q_valid;
	assign emit = active_q && (wait_q == '0) && (!out_valid || !out_stall);

	always_comb begin
		nxt_scl  = scl_q;
		nxt_sda  = sda_q;
		nxt_held = 1'b1;
		nxt_last = 1'b0;
		case (job_q.command)
			CMD_START: begin
				case (step_q)
					5'd0:    nxt_sda = 1'b1;
					5'd1:    nxt_scl = 1'b1;
					5'd2:    nxt_sda = 1'b0;
					default: begin
						nxt_scl  = 1'b0;
						nxt_last = 1'b1;
					end
				endcase
			end
			CMD_STOP: begin
				case (step_q)
					5'd0:    nxt_sda = 1'b0;
					5'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_sda  = 1'b1;
						nxt_last = 1'b1;
					end
				endcase
			end
			CMD_WRITE: begin
				case (sub_q)
					2'd0:    nxt_sda = (grp_q == 4'd8) ? 1'b1
						: job_q.tx_byte[3'd7 - grp_q[2:0]];
					2'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_scl  = 1'b0;
						nxt_last = grp_q == 4'd8;
					end
				endcase
			end
			CMD_READ: begin
				if (step_q == 5'd0) begin
					nxt_sda = 1'b1;
				end else if (step_q inside {[5'd1:5'd16]}) begin
					nxt_scl  = step_q[0];
					nxt_held = step_q != 5'd16;
				end else if (step_q == 5'd17) begin
					nxt_sda = job_q.send_nack;
				end else if (step_q == 5'd18) begin
					nxt_scl = 1'b1;
				end else if (step_q == 5'd19) begin
					nxt_scl = 1'b0;
				end else begin
					nxt_sda  = 1'b1;
					nxt_held = 1'b0;
					nxt_last = 1'b1;
				end
			end
			CMD_READ_ACK: begin
				case (step_q)
					5'd0:    nxt_sda = 1'b1;
					5'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_scl  = 1'b0;
						nxt_last = 1'b1;
					end
				endcase
			end
			default: nxt_last = 1'b1;
		endcase
		nxt_rx  = (nxt_last && job_q.command == CMD_READ) ? job_q.line_samples[7:0] : 8'd0;
		nxt_ack = nxt_last && (job_q.command == CMD_WRITE || job_q.command == CMD_READ_ACK)
			&& job_q.line_samples[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			active_q      <= 1'b0;
			step_q        <= '0;
			sub_q         <= '0;
			grp_q         <= '0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			wait_q        <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				phase_ticks_q <= cfg_wdata;
			end
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= '0;
				sub_q    <= '0;
				grp_q    <= '0;
			end else if (emit) begin
				active_q <= !nxt_last;
				step_q   <= step_q + 1'b1;
				sub_q    <= (sub_q == 2'd2) ? 2'd0 : sub_q + 1'b1;
				grp_q    <= grp_q + {3'd0, sub_q == 2'd2};
			end
			if (emit) begin
				scl_q     <= nxt_scl;
				sda_q     <= nxt_sda;
				wait_q    <= nxt_held ? phase_ticks_q : 8'd0;
				out_valid <= 1'b1;
			end else begin
				if (wait_q != '0) begin
					wait_q <= wait_q - 1'b1;
				end
				if (!out_stall) begin
					out_valid <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_cmd;
		end
		if (emit) begin
			scl_level <= nxt_scl;
			sda_level <= nxt_sda;
			held      <= nxt_held;
			rx_byte   <= nxt_rx;
			ack_seen  <= nxt_ack;
			last      <= nxt_last;
		end
	end

endmodule
